### hw/rtl/enl_pkg.sv
// enl_pkg: shared types, widths and codes for the extent node lookup block
// no dependencies; imported by every rtl file of the block
package enl_pkg;

  // node capacity and derived widths
  localparam int NODE_ENTRIES = 512;
  localparam int SLOT_W       = $clog2(NODE_ENTRIES);
  localparam int CNT_W        = $clog2(NODE_ENTRIES + 1);

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int HALF_W   = 16;
  localparam int KEY_W    = 32;
  localparam int LEN_W    = 16;
  localparam int TGT_W    = 48;
  localparam int BLK_W    = 64;
  localparam int STAT_W   = 3;
  localparam int FSLOT_W  = 9;
  localparam int CFG_IDX_W = 1;

  // configuration reset values
  localparam logic [HALF_W-1:0] MAGIC_RESET     = 16'hF30A;
  localparam logic [HALF_W-1:0] MAX_DEPTH_RESET = 16'd5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENTRY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_FOUND   = 3'd0,
    ST_DESCEND = 3'd1,
    ST_NOMAP   = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_ACCEPT  = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MAGIC   = 1'b0,
    REG_MAX_TREE_DEPTH = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [HALF_W-1:0] hdr_magic;
    logic [HALF_W-1:0] hdr_entry_count;
    logic [HALF_W-1:0] hdr_entry_max;
    logic [HALF_W-1:0] hdr_depth;
    logic [HALF_W-1:0] expected_depth;
    logic              check_depth;
    logic [KEY_W-1:0]  entry_key;
    logic [LEN_W-1:0]  entry_length;
    logic [TGT_W-1:0]  entry_target;
    logic [BLK_W-1:0]  logical_block;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FSLOT_W-1:0] found_slot;
    logic [KEY_W-1:0]   found_key;
    logic [LEN_W-1:0]   found_length;
    logic [TGT_W-1:0]   found_target;
  } rsp_t;

  // one stored slot
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] length;
    logic [TGT_W-1:0] target;
  } slot_t;

  // configuration seen by the controller
  typedef struct packed {
    logic [HALF_W-1:0] header_magic;
    logic [HALF_W-1:0] max_tree_depth;
  } cfg_t;

endpackage

### hw/rtl/enl_channels.sv
// enl_channels: valid/ready channel interfaces for requests and results
// depends on enl_pkg for the payload structs
interface enl_req_if
  import enl_pkg::*;
;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface enl_rsp_if
  import enl_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/enl_slot_mem.sv
// enl_slot_mem: slot storage, one write port and one registered read port
// depends on enl_pkg for slot_t and the node size
module enl_slot_mem
  import enl_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_t             wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_t             rd_data
);

  slot_t mem [NODE_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/enl_ctrl.sv
// enl_ctrl: header check, node state, slot loading, binary search sequencer
// and result register; depends on enl_pkg, enl_channels and enl_slot_mem
module enl_ctrl
  import enl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  enl_req_if.sink    req,
  enl_rsp_if.source  rsp
);

  state_t state, state_next;

  // node state
  logic [CNT_W-1:0]  node_count;
  logic [HALF_W-1:0] node_level;
  logic              node_valid;
  logic [CNT_W-1:0]  load_pointer;

  // search registers
  logic [KEY_W-1:0]  blk;
  logic [CNT_W-1:0]  lo, hi, mid;
  logic [CNT_W-1:0]  lo_next, hi_next, mid_next;

  // result register
  logic rsp_valid;
  rsp_t rsp_data;
  rsp_t res_next;
  logic res_load;

  // memory port signals
  logic              wr_en;
  slot_t             wr_data;
  logic              rd_en;
  slot_t             rd_data;

  logic acc, out_free;
  logic hdr_bad, lookup_nomap, entry_room, search_done;
  logic node_load, node_clear, entry_take, lookup_start, search_step;
  logic go_left, covers;
  logic [KEY_W:0] end_blk;

  enl_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_pointer[SLOT_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (mid_next[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  assign out_free = !rsp_valid || rsp.ready;
  assign acc      = req.valid && req.ready;

  // header check
  assign hdr_bad = (req.data.hdr_depth > cfg.max_tree_depth) ||
                   (req.data.hdr_magic != cfg.header_magic) ||
                   (req.data.hdr_entry_count > req.data.hdr_entry_max) ||
                   (req.data.hdr_entry_count > HALF_W'(NODE_ENTRIES)) ||
                   (req.data.check_depth &&
                    (req.data.hdr_depth != req.data.expected_depth));

  // lookups answered without a search
  assign lookup_nomap = !node_valid || (req.data.logical_block[BLK_W-1:KEY_W] != '0) ||
                        (node_count == '0);

  assign entry_room = load_pointer < CNT_W'(NODE_ENTRIES);

  // one probe: compare and narrow the range
  assign go_left = blk < rd_data.key;
  always_comb begin
    lo_next = go_left ? lo : mid + CNT_W'(1);
    hi_next = go_left ? mid - CNT_W'(1) : hi;
  end
  assign search_done = lo_next > hi_next;

  // coverage test, key plus length without wrap
  assign end_blk = {1'b0, rd_data.key} + {{(KEY_W+1-LEN_W){1'b0}}, rd_data.length};
  assign covers  = (blk >= rd_data.key) && (end_blk > {1'b0, blk});

  assign wr_data = '{key: req.data.entry_key, length: req.data.entry_length,
                     target: req.data.entry_target};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && req.data.command == CMD_LOOKUP && !lookup_nomap) begin
          state_next = (node_count == CNT_W'(1)) ? S_FINAL : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_done) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    req.ready    = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    res_load     = 1'b0;
    res_next     = '0;
    node_load    = 1'b0;
    node_clear   = 1'b0;
    entry_take   = 1'b0;
    lookup_start = 1'b0;
    search_step  = 1'b0;
    mid_next     = mid;
    unique case (state)
      S_IDLE: begin
        req.ready = out_free;
        // first probe address, or slot zero for a single entry node
        mid_next  = (node_count == CNT_W'(1)) ? '0 :
                    CNT_W'(1) + ((node_count - CNT_W'(2)) >> 1);
        if (acc) begin
          priority case (req.data.command)
            CMD_HEADER: begin
              res_load        = 1'b1;
              res_next.status = hdr_bad ? ST_CORRUPT : ST_ACCEPT;
              node_load       = !hdr_bad;
              node_clear      = hdr_bad;
            end
            CMD_ENTRY: begin
              res_load        = 1'b1;
              res_next.status = ST_ACCEPT;
              if (entry_room) begin
                wr_en                 = 1'b1;
                entry_take            = 1'b1;
                res_next.found_slot   = FSLOT_W'(load_pointer);
                res_next.found_key    = req.data.entry_key;
                res_next.found_length = req.data.entry_length;
                res_next.found_target = req.data.entry_target;
              end
            end
            CMD_LOOKUP: begin
              if (lookup_nomap) begin
                res_load        = 1'b1;
                res_next.status = ST_NOMAP;
              end else begin
                rd_en        = 1'b1;
                lookup_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        rd_en       = 1'b1;
        search_step = 1'b1;
        mid_next    = search_done ? lo_next - CNT_W'(1) :
                      lo_next + ((hi_next - lo_next) >> 1);
      end
      S_FINAL: begin
        res_load = out_free;
        if (node_level != '0) begin
          res_next.status       = ST_DESCEND;
          res_next.found_slot   = FSLOT_W'(mid);
          res_next.found_key    = rd_data.key;
          res_next.found_target = rd_data.target;
        end else if (covers) begin
          res_next.status       = ST_FOUND;
          res_next.found_slot   = FSLOT_W'(mid);
          res_next.found_key    = rd_data.key;
          res_next.found_length = rd_data.length;
          res_next.found_target = rd_data.target;
        end else begin
          res_next.status = ST_NOMAP;
        end
      end
      default: ;
    endcase
  end

  // state and node registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      node_count   <= '0;
      node_level   <= '0;
      node_valid   <= 1'b0;
      load_pointer <= '0;
    end else begin
      state <= state_next;
      if (node_load) begin
        node_valid   <= 1'b1;
        node_count   <= CNT_W'(req.data.hdr_entry_count);
        node_level   <= req.data.hdr_depth;
        load_pointer <= '0;
      end else if (node_clear) begin
        node_valid <= 1'b0;
      end
      if (entry_take) begin
        load_pointer <= load_pointer + CNT_W'(1);
      end
    end
  end

  // search range registers
  always_ff @(posedge clk) begin
    if (lookup_start) begin
      blk <= req.data.logical_block[KEY_W-1:0];
      lo  <= CNT_W'(1);
      hi  <= node_count - CNT_W'(1);
    end else if (search_step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (rd_en) begin
      mid <= mid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp_data <= res_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

### hw/rtl/extent_node_lookup.sv
// extent_node_lookup: top level with configuration registers
// depends on enl_pkg, enl_channels, enl_ctrl and enl_slot_mem
//
// Holds one extent-tree node and answers block lookups in it.
// req channel: one request per item; command selects header load, entry
//   load or lookup. rsp channel: one result per header, entry or lookup;
//   an unknown command is taken and answered by nothing.
// Header and entry requests, and lookups answered without a search (no
//   valid node, block above 32 bits, empty node), give their result in the
//   cycle after the request is taken.
// A lookup reads the slot memory once per probe of the binary search over
//   slots 1 to count-1, then once more for the chosen slot, through the
//   single read port of the slot memory. One request is worked on at a
//   time; the next is taken when the block is back in idle.
// Results sit in an output register; while a result waits there, the block
//   takes no new request, and a finished lookup holds in its last step
//   until that register frees.
// Reset clears the node (no valid node, zero count), the load pointer, the
//   result register and sets the configuration to its defaults. Slot
//   contents are not cleared. The user must write the configuration through
//   cfg_we, cfg_index and cfg_data only while the block is idle (unchecked).
module extent_node_lookup
  import enl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  enl_req_if.sink              req,
  enl_rsp_if.source            rsp
);

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_magic   <= MAGIC_RESET;
      cfg.max_tree_depth <= MAX_DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_MAGIC:   cfg.header_magic   <= cfg_data;
        REG_MAX_TREE_DEPTH: cfg.max_tree_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  enl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

endmodule

### hw/rtl/enl_checker.sv
// enl_checker: port-level assertions for extent_node_lookup, with its bind
// depends on enl_pkg for command and status codes
module enl_checker
  import enl_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic [CMD_W-1:0]  req_command,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input rsp_t              rsp_data
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a header request is answered in the next cycle with accept or corrupt
  a_hdr_answer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_HEADER |=>
      rsp_valid && (rsp_data.status == ST_ACCEPT || rsp_data.status == ST_CORRUPT))
    else $error("header request not answered");

  // no mapping carries zero fields
  a_nomap_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_NOMAP |->
      rsp_data.found_slot == '0 && rsp_data.found_key == '0 &&
      rsp_data.found_length == '0 && rsp_data.found_target == '0)
    else $error("no mapping result with nonzero fields");

endmodule

bind extent_node_lookup enl_checker u_enl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.data.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_data    (rsp.data)
);

### verif/extent_node_lookup_test.sv
`timescale 1ns / 100ps
// extent_node_lookup_test: self-checking testbench for the extent node lookup block
// depends on enl_pkg, the enl_channels interfaces and the extent_node_lookup rtl
module extent_node_lookup_test
  import enl_pkg::*;
;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HALF_W-1:0] cfg_data;

  enl_req_if req_ch ();
  enl_rsp_if rsp_ch ();

  extent_node_lookup i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // mirror of the node held by the block
  logic [KEY_W-1:0] node_key [NODE_ENTRIES] = '{default: '0};
  logic [LEN_W-1:0] node_len [NODE_ENTRIES] = '{default: '0};
  logic [TGT_W-1:0] node_tgt [NODE_ENTRIES] = '{default: '0};
  int node_entries = 0;
  logic [HALF_W-1:0] node_depth = '0;
  bit node_live = 1'b0;
  int fill_ptr = 0;
  int slots_written = 0;
  logic [HALF_W-1:0] magic_cfg = MAGIC_RESET;
  logic [HALF_W-1:0] depth_cfg = MAX_DEPTH_RESET;

  rsp_t pending_results [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // expected result for one request; updates the mirrored node
  function automatic bit compute_response(input req_t r, output rsp_t res);
    int lo;
    int hi;
    int mid;
    int pick;
    logic [KEY_W:0] reach;
    bit bad;
    res = '0;
    case (r.command)
      CMD_HEADER: begin
        bad = (r.hdr_depth > depth_cfg) || (r.hdr_magic != magic_cfg) ||
              (r.hdr_entry_count > r.hdr_entry_max) ||
              (r.hdr_entry_count > NODE_ENTRIES) ||
              (r.check_depth && r.hdr_depth != r.expected_depth);
        if (bad) begin
          node_live = 1'b0;
          res.status = ST_CORRUPT;
        end else begin
          node_live = 1'b1;
          node_entries = int'(r.hdr_entry_count);
          node_depth = r.hdr_depth;
          fill_ptr = 0;
          res.status = ST_ACCEPT;
        end
        return 1'b1;
      end
      CMD_ENTRY: begin
        res.status = ST_ACCEPT;
        // entries past the node capacity are dropped
        if (fill_ptr < NODE_ENTRIES) begin
          node_key[fill_ptr] = r.entry_key;
          node_len[fill_ptr] = r.entry_length;
          node_tgt[fill_ptr] = r.entry_target;
          res.found_slot = FSLOT_W'(fill_ptr);
          res.found_key = r.entry_key;
          res.found_length = r.entry_length;
          res.found_target = r.entry_target;
          fill_ptr++;
          if (fill_ptr > slots_written) slots_written = fill_ptr;
        end
        return 1'b1;
      end
      CMD_LOOKUP: begin
        if (!node_live || r.logical_block[63:32] != '0 || node_entries == 0) begin
          res.status = ST_NOMAP;
          return 1'b1;
        end
        // last key not above the block among slots 1..count-1, else slot 0
        lo = 1;
        hi = node_entries - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (r.logical_block < {32'b0, node_key[mid]}) hi = mid - 1;
          else lo = mid + 1;
        end
        pick = lo - 1;
        if (node_depth != '0) begin
          res.status = ST_DESCEND;
          res.found_slot = FSLOT_W'(pick);
          res.found_key = node_key[pick];
          res.found_target = node_tgt[pick];
          return 1'b1;
        end
        // coverage without wrap
        reach = {1'b0, node_key[pick]} + {17'b0, node_len[pick]};
        if (r.logical_block[31:0] >= node_key[pick] &&
            reach > {1'b0, r.logical_block[31:0]}) begin
          res.status = ST_FOUND;
          res.found_slot = FSLOT_W'(pick);
          res.found_key = node_key[pick];
          res.found_length = node_len[pick];
          res.found_target = node_tgt[pick];
        end else begin
          res.status = ST_NOMAP;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // a lookup must never read a slot that was never written
  function automatic bit lookup_is_safe(input logic [BLK_W-1:0] blk);
    return !node_live || blk[63:32] != '0 || node_entries == 0 ||
           node_entries <= slots_written;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.command = CMD_W'($urandom);
    r.hdr_magic = HALF_W'($urandom);
    r.hdr_entry_count = HALF_W'($urandom);
    r.hdr_entry_max = HALF_W'($urandom);
    r.hdr_depth = HALF_W'($urandom);
    r.expected_depth = HALF_W'($urandom);
    r.check_depth = 1'($urandom_range(1));
    r.entry_key = $urandom;
    r.entry_length = LEN_W'($urandom);
    r.entry_target = TGT_W'({$urandom, $urandom});
    r.logical_block = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t header_request(input logic [HALF_W-1:0] magic, count, emax,
                                          depth, expect_depth, input bit chk);
    req_t r;
    r = random_request();
    r.command = CMD_HEADER;
    r.hdr_magic = magic;
    r.hdr_entry_count = count;
    r.hdr_entry_max = emax;
    r.hdr_depth = depth;
    r.expected_depth = expect_depth;
    r.check_depth = chk;
    return r;
  endfunction

  function automatic req_t entry_request(input logic [KEY_W-1:0] key,
                                         input logic [LEN_W-1:0] len,
                                         input logic [TGT_W-1:0] tgt);
    req_t r;
    r = random_request();
    r.command = CMD_ENTRY;
    r.entry_key = key;
    r.entry_length = len;
    r.entry_target = tgt;
    return r;
  endfunction

  function automatic req_t lookup_request(input logic [BLK_W-1:0] blk);
    req_t r;
    r = random_request();
    r.command = CMD_LOOKUP;
    r.logical_block = blk;
    return r;
  endfunction

  // offer one request, with random idle cycles first, and record its result
  task automatic send_request(input req_t item);
    req_t r;
    rsp_t res;
    r = item;
    if (r.command == CMD_LOOKUP && !lookup_is_safe(r.logical_block)) r.command = CMD_ENTRY;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (compute_response(r, res)) begin
      pending_results.push_back(res);
      items_sent++;
    end
  endtask

  // stop offering, drain all results, then let the block settle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [HALF_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == REG_HEADER_MAGIC) magic_cfg = value;
    else depth_cfg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // lookups aimed mostly at the slots of the current node, some at random blocks
  task automatic send_lookups(input int count, input int n);
    int s;
    logic [BLK_W-1:0] blk;
    repeat (n) begin
      s = $urandom_range(0, (count > 0) ? count - 1 : 0);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: blk = BLK_W'(node_key[s]) + BLK_W'($urandom_range(0, node_len[s]));
        5: blk = BLK_W'(node_key[s]) + BLK_W'(node_len[s]);
        6: blk = BLK_W'(node_key[s]) - BLK_W'(1);
        7: blk = BLK_W'($urandom);
        8: blk = {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
        default: blk = {$urandom, $urandom};
      endcase
      send_request(lookup_request(blk));
    end
  endtask

  // header, its entries in key order, then lookups; optionally a bad header
  task automatic send_node(input int count, input int level, input int n_lookups,
                           input bit broken);
    req_t r;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    r = header_request(magic_cfg, HALF_W'(count),
                       HALF_W'(count + $urandom_range(0, 3) * $urandom_range(0, 200)),
                       HALF_W'(level), HALF_W'($urandom), 1'($urandom_range(1)));
    if (r.check_depth) r.expected_depth = HALF_W'(level);
    if (broken) begin
      case ($urandom_range(4))
        0: r.hdr_magic = magic_cfg ^ (16'h1 << $urandom_range(15));
        1: begin
          r.hdr_entry_max = HALF_W'(count);
          r.hdr_entry_count = HALF_W'(count + 1);
        end
        2: begin
          r.hdr_entry_count = HALF_W'(NODE_ENTRIES + 1 + $urandom_range(0, 60000));
          r.hdr_entry_max = 16'hFFFF;
        end
        3: begin
          r.check_depth = 1'b1;
          r.expected_depth = HALF_W'(level + 1 + $urandom_range(0, 10));
        end
        default: begin
          if (depth_cfg != 16'hFFFF) begin
            r.hdr_depth = HALF_W'(depth_cfg + 1 + $urandom_range(0, 3));
          end else begin
            r.hdr_magic = ~magic_cfg;
          end
        end
      endcase
    end
    send_request(r);
    key = $urandom;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: len = '0;
        1, 2: len = LEN_W'($urandom_range(1, 64));
        default: len = LEN_W'($urandom);
      endcase
      send_request(entry_request(key, len, TGT_W'({$urandom, $urandom})));
      key = key + len + (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 70000));
    end
    send_lookups(count, n_lookups);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d", rsp_ch.data.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.data.status);
          mismatch_count++;
        end
        if (rsp_ch.data.found_slot !== want.found_slot) begin
          $error("found_slot: expected %0d, actual %0d", want.found_slot,
                 rsp_ch.data.found_slot);
          mismatch_count++;
        end
        if (rsp_ch.data.found_key !== want.found_key) begin
          $error("found_key: expected %h, actual %h", want.found_key, rsp_ch.data.found_key);
          mismatch_count++;
        end
        if (rsp_ch.data.found_length !== want.found_length) begin
          $error("found_length: expected %h, actual %h", want.found_length,
                 rsp_ch.data.found_length);
          mismatch_count++;
        end
        if (rsp_ch.data.found_target !== want.found_target) begin
          $error("found_target: expected %h, actual %h", want.found_target,
                 rsp_ch.data.found_target);
          mismatch_count++;
        end
      end
    end
  end

  // result ready: random stalls, or a long hold-off on request
  initial begin : ready_drive
    int held;
    held = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && held < HOLD_CYCLES) begin
        rsp_ch.ready <= 1'b0;
        held++;
      end else begin
        if (held >= HOLD_CYCLES) begin
          hold_request = 1'b0;
          held = 0;
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // lookup with no node ever loaded
  task automatic test_no_node();
    send_request(lookup_request(64'd0));
  endtask

  // each header check on its own, with the reset configuration
  task automatic test_header_checks();
    send_request(header_request(MAGIC_RESET, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_request(header_request(MAGIC_RESET, 16'd1, 16'd1, MAX_DEPTH_RESET + 16'd1,
                                16'd0, 1'b0));
    send_request(header_request(MAGIC_RESET ^ 16'h1, 16'd1, 16'd1, 16'd0, 16'd0, 1'b0));
    send_request(header_request(MAGIC_RESET, 16'd5, 16'd4, 16'd0, 16'd0, 1'b0));
    send_request(header_request(MAGIC_RESET, HALF_W'(NODE_ENTRIES + 1), 16'd600, 16'd0,
                                16'd0, 1'b0));
    send_request(header_request(MAGIC_RESET, 16'd1, 16'd1, 16'd3, 16'd2, 1'b1));
    // rejected header leaves no valid node
    send_request(lookup_request(64'd0));
    send_request(header_request(MAGIC_RESET, HALF_W'(NODE_ENTRIES), HALF_W'(NODE_ENTRIES),
                                MAX_DEPTH_RESET, MAX_DEPTH_RESET, 1'b1));
  endtask

  // leaf: fallback slot, hits, zero length, no wrap at the top, wide blocks
  task automatic test_leaf_lookup();
    send_request(header_request(MAGIC_RESET, 16'd4, 16'd4, 16'd0, 16'd0, 1'b0));
    send_request(entry_request(32'd10, 16'd10, 48'hFFFF_FFFF_FFFF));
    send_request(entry_request(32'd100, 16'd50, 48'h0));
    send_request(entry_request(32'd200, 16'd0, 48'h8000_0000_0001));
    send_request(entry_request(32'hFFFF_FF00, 16'hFFFF, 48'h1234_5678_9ABC));
    send_request(lookup_request(64'd3));
    send_request(lookup_request(64'd15));
    send_request(lookup_request(64'd120));
    send_request(lookup_request(64'd200));
    send_request(lookup_request(64'hFFFF_FFFF));
    send_request(lookup_request(64'h1_0000_0000));
    send_request(lookup_request(64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  // index node answers descend; empty index node gives no mapping
  task automatic test_index_lookup();
    send_request(header_request(MAGIC_RESET, 16'd4, 16'd4, 16'd2, 16'd2, 1'b1));
    send_request(lookup_request(64'd150));
    send_request(lookup_request(64'd5));
    send_request(header_request(MAGIC_RESET, 16'd0, 16'd0, 16'd1, 16'd0, 1'b0));
    send_request(lookup_request(64'd7));
  endtask

  // unknown command is taken and answered by nothing
  task automatic test_unknown_command();
    req_t r;
    r = random_request();
    r.command = CMD_UNKNOWN;
    send_request(r);
    send_request(lookup_request(64'd7));
  endtask

  // full node, one entry past capacity, lookups at random slots of the full node
  task automatic test_full_node();
    send_node(NODE_ENTRIES, 0, 0, 1'b0);
    send_request(entry_request($urandom, LEN_W'($urandom), TGT_W'({$urandom, $urandom})));
    send_lookups(NODE_ENTRIES, 30);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    send_node(16, 0, 30, 1'b0);
    while (hold_request) @(posedge clk);
    wait_idle();
  endtask

  // mostly well-formed nodes with random content, some noise
  task automatic test_random_phase(input logic [HALF_W-1:0] magic, depth, input int n_items,
                                   input int send_pct, input int recv_pct);
    int sent_before;
    int count;
    int pick;
    wait_idle();
    write_register(REG_HEADER_MAGIC, magic);
    write_register(REG_MAX_TREE_DEPTH, depth);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent_before = items_sent;
    while (items_sent - sent_before < n_items) begin
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(99);
        if (pick < 70) count = $urandom_range(0, 8);
        else if (pick < 95) count = $urandom_range(9, 64);
        else count = $urandom_range(65, NODE_ENTRIES);
        send_node(count, $urandom_range(1) ? 0 : $urandom_range(0, depth_cfg),
                  $urandom_range(1, 8), $urandom_range(99) < 10);
      end else begin
        repeat ($urandom_range(1, 4)) send_request(random_request());
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_HEADER_MAGIC;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_node();
    test_header_checks();
    test_leaf_lookup();
    test_index_lookup();
    test_unknown_command();
    test_full_node();
    test_backpressure();
    test_random_phase(16'h0000, 16'h0000, 400, 0, 0);
    test_random_phase(16'hFFFF, 16'hFFFF, 400, 82, 0);
    test_random_phase(HALF_W'($urandom), HALF_W'($urandom_range(0, 8)), 400, 0, 82);
    test_random_phase(MAGIC_RESET, MAX_DEPTH_RESET, 400, 18, 18);
    wait_idle();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
